// ----- hdl/grid_astar_path_search_unit_defines.svh -----
// assertion macros for the grid path search unit
`ifndef GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GAS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define GAS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/gas_pkg.sv -----
// shared types and constants of the grid path search unit
package gas_pkg;

	localparam int COST_W = 11;
	localparam logic [COST_W-1:0] COST_INF = 11'd2047;
	localparam logic [COST_W-1:0] COST_MAX = 11'd2046;
	localparam int F_W = COST_W + 2;

	localparam logic [1:0] ACT_WRITE  = 2'd0;
	localparam logic [1:0] ACT_SEARCH = 2'd1;
	localparam logic [1:0] ACT_READ   = 2'd2;

	// up, down, left, right, up-left, down-left, up-right, down-right
	localparam logic signed [1:0] DIR_DX [8] = '{2'sd0, 2'sd0, -2'sd1, 2'sd1,
		-2'sd1, -2'sd1, 2'sd1, 2'sd1};
	localparam logic signed [1:0] DIR_DY [8] = '{-2'sd1, 2'sd1, 2'sd0, 2'sd0,
		-2'sd1, 2'sd1, -2'sd1, 2'sd1};

	typedef struct packed {
		logic              open;
		logic [COST_W-1:0] cost;
		logic [2:0]        dir;
	} cell_t;

	localparam int CELL_W = $bits(cell_t);

	typedef struct packed {
		logic done;
		logic found;
	} srch_stat_t;

endpackage

// ----- hdl/grid_astar_path_search_unit.sv -----
// top level of the grid path search unit
// One beat in gives one beat out. A search with start and goal on the grid clears the cell
// memory in one pass, then makes one full read sweep of the cell memory for every expansion,
// then a read step for each of the eight neighbor directions and an update step for each
// on-grid neighbor, and at the end two trace passes over the path cells. After reset the
// obstacle memory is cleared cell by cell before the first beat is taken.
`include "grid_astar_path_search_unit_defines.svh"

module grid_astar_path_search_unit #(
	parameter int GRID_HALF = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        action,
	input  logic signed [4:0] cell_x,
	input  logic signed [4:0] cell_y,
	input  logic              blocked,
	input  logic signed [4:0] goal_x,
	input  logic signed [4:0] goal_y,
	input  logic [9:0]        step_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              found,
	output logic [10:0]       path_length,
	output logic              index_valid,
	output logic signed [4:0] step_x,
	output logic signed [4:0] step_y
);

	localparam int SIDE   = 2 * GRID_HALF;
	localparam int NCELLS = SIDE * SIDE;
	localparam int UW     = $clog2(SIDE);
	localparam int AW     = $clog2(NCELLS);
	localparam int LW     = $clog2(NCELLS + 1);
	localparam int SW     = ((UW > 5) ? UW : 5) + 2;
	localparam logic signed [SW-1:0] GH_S   = SW'(GRID_HALF);
	localparam logic signed [SW-1:0] SIDE_S = SW'(SIDE);

	localparam logic [2:0] T_CLR  = 3'd0;
	localparam logic [2:0] T_IDLE = 3'd1;
	localparam logic [2:0] T_SRCH = 3'd2;
	localparam logic [2:0] T_RD   = 3'd3;
	localparam logic [2:0] T_OUT  = 3'd4;

	logic [2:0] st_q;
	logic [LW-1:0] clr_q;
	logic found_q;
	logic [LW-1:0] len_q;
	logic pend_iv_q;
	logic signed [4:0] pend_x_q, pend_y_q;
	logic out_valid_q, out_found_q, out_iv_q;
	logic [10:0] out_len_q;
	logic signed [4:0] out_x_q, out_y_q;

	logic accept;
	logic signed [SW-1:0] cu_c, cv_c, gu_c, gv_c, rx_c, ry_c;
	logic c_on, g_on;
	logic obs_we, obs_wd;
	logic [AW-1:0] obs_waddr, obs_raddr;
	logic obs_rdata;
	logic path_we;
	logic [AW-1:0] path_waddr;
	logic [2*UW-1:0] path_wdata, path_rdata;
	gas_pkg::srch_stat_t stat;
	logic [LW-1:0] srch_len;

	assign accept = in_valid && in_ready;
	assign in_ready = (st_q == T_IDLE);

	always_comb begin
		cu_c = $signed(SW'(cell_x)) + GH_S;
		cv_c = $signed(SW'(cell_y)) + GH_S;
		gu_c = $signed(SW'(goal_x)) + GH_S;
		gv_c = $signed(SW'(goal_y)) + GH_S;
		c_on = (cu_c >= 0) && (cu_c < SIDE_S) && (cv_c >= 0) && (cv_c < SIDE_S);
		g_on = (gu_c >= 0) && (gu_c < SIDE_S) && (gv_c >= 0) && (gv_c < SIDE_S);
		rx_c = $signed(SW'(path_rdata[2*UW-1:UW])) - GH_S;
		ry_c = $signed(SW'(path_rdata[UW-1:0])) - GH_S;
		obs_we    = (st_q == T_CLR) || (accept && (action == gas_pkg::ACT_WRITE) && c_on);
		obs_wd    = (st_q == T_CLR) ? 1'b0 : blocked;
		obs_waddr = (st_q == T_CLR) ? clr_q[AW-1:0] :
			AW'(cu_c[UW-1:0] * SIDE + cv_c[UW-1:0]);
	end

	gas_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_obs_ram (
		.clk   (clk),
		.we    (obs_we),
		.waddr (obs_waddr),
		.wdata (obs_wd),
		.raddr (obs_raddr),
		.rdata (obs_rdata)
	);

	gas_ram #(.WIDTH(2 * UW), .DEPTH(NCELLS)) u_path_ram (
		.clk   (clk),
		.we    (path_we),
		.waddr (path_waddr),
		.wdata (path_wdata),
		.raddr (AW'(step_index)),
		.rdata (path_rdata)
	);

	gas_search #(.GRID_HALF(GRID_HALF)) u_search (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept && (action == gas_pkg::ACT_SEARCH)),
		.ok         (c_on && g_on),
		.su         (cu_c[UW-1:0]),
		.sv         (cv_c[UW-1:0]),
		.gu         (gu_c[UW-1:0]),
		.gv         (gv_c[UW-1:0]),
		.obs_raddr  (obs_raddr),
		.obs_rdata  (obs_rdata),
		.path_we    (path_we),
		.path_waddr (path_waddr),
		.path_wdata (path_wdata),
		.stat       (stat),
		.len        (srch_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= T_CLR;
			clr_q       <= '0;
			found_q     <= 1'b0;
			len_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((st_q == T_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				T_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LW'(NCELLS - 1)) begin
						st_q <= T_IDLE;
					end
				end
				T_IDLE: begin
					if (accept) begin
						pend_iv_q <= (action == gas_pkg::ACT_READ) &&
							(32'(step_index) < 32'(len_q)) &&
							(32'(step_index) < NCELLS);
						pend_x_q  <= '0;
						pend_y_q  <= '0;
						case (action)
							gas_pkg::ACT_SEARCH: st_q <= T_SRCH;
							gas_pkg::ACT_READ: st_q <= T_RD;
							default: st_q <= T_OUT;
						endcase
					end
				end
				T_SRCH: begin
					if (stat.done) begin
						found_q <= stat.found;
						len_q   <= srch_len;
						st_q    <= T_OUT;
					end
				end
				T_RD: begin
					if (pend_iv_q) begin
						pend_x_q <= rx_c[4:0];
						pend_y_q <= ry_c[4:0];
					end
					st_q <= T_OUT;
				end
				T_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_found_q <= found_q;
						out_len_q   <= 11'(len_q);
						out_iv_q    <= pend_iv_q;
						out_x_q     <= pend_x_q;
						out_y_q     <= pend_y_q;
						st_q        <= T_IDLE;
					end
				end
				default: st_q <= T_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_found_q;
	assign path_length = out_len_q;
	assign index_valid = out_iv_q;
	assign step_x      = out_x_q;
	assign step_y      = out_y_q;

	`GAS_ASSERT_SAME(a_done_in_search, clk, arst_n, stat.done, st_q == T_SRCH, "search done outside search")
	`GAS_ASSERT_SAME(a_iv_needs_path, clk, arst_n, out_valid_q && out_iv_q, out_len_q != 11'd0, "index valid with empty path")
	`GAS_ASSERT_SAME(a_nofound_empty, clk, arst_n, out_valid_q && !out_found_q, out_len_q == 11'd0, "path length without found")
	`GAS_ASSERT_NEXT(a_out_loads_idle, clk, arst_n, (st_q == T_OUT) && (!out_valid_q || out_ready), out_valid_q && (st_q == T_IDLE), "result not loaded")

endmodule

// ----- hdl/gas_ram.sv -----
// generic single write port ram with registered read
module gas_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/gas_search.sv -----
// search engine: cell memory sweep, expansion and path trace
module gas_search #(
	parameter int GRID_HALF = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  logic                                       ok,
	input  logic [$clog2(2*GRID_HALF)-1:0]             su,
	input  logic [$clog2(2*GRID_HALF)-1:0]             sv,
	input  logic [$clog2(2*GRID_HALF)-1:0]             gu,
	input  logic [$clog2(2*GRID_HALF)-1:0]             gv,
	output logic [$clog2(4*GRID_HALF*GRID_HALF)-1:0]   obs_raddr,
	input  logic                                       obs_rdata,
	output logic                                       path_we,
	output logic [$clog2(4*GRID_HALF*GRID_HALF)-1:0]   path_waddr,
	output logic [2*$clog2(2*GRID_HALF)-1:0]           path_wdata,
	output gas_pkg::srch_stat_t                        stat,
	output logic [$clog2(4*GRID_HALF*GRID_HALF+1)-1:0] len
);

	localparam int SIDE   = 2 * GRID_HALF;
	localparam int NCELLS = SIDE * SIDE;
	localparam int UW     = $clog2(SIDE);
	localparam int AW     = $clog2(NCELLS);
	localparam int LW     = $clog2(NCELLS + 1);
	localparam int SW     = ((UW > 5) ? UW : 5) + 2;
	localparam logic signed [SW-1:0] SIDE_S = SW'(SIDE);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_INIT   = 4'd2;
	localparam logic [3:0] S_SEL    = 4'd3;
	localparam logic [3:0] S_PICK   = 4'd4;
	localparam logic [3:0] S_NRD    = 4'd5;
	localparam logic [3:0] S_NWR    = 4'd6;
	localparam logic [3:0] S_CNT_RD = 4'd7;
	localparam logic [3:0] S_CNT_EV = 4'd8;
	localparam logic [3:0] S_ST_INI = 4'd9;
	localparam logic [3:0] S_ST_RD  = 4'd10;
	localparam logic [3:0] S_ST_EV  = 4'd11;
	localparam logic [3:0] S_DONE   = 4'd12;

	logic [3:0] st_q;
	logic [LW-1:0] sweep_q;
	logic [UW-1:0] swu_q, swv_q;
	logic sel_v_s1, sel_last_s1;
	logic [AW-1:0] sel_a_s1;
	logic [UW-1:0] sel_u_s1, sel_w_s1;
	logic have_q;
	logic [gas_pkg::F_W-1:0] bf_q;
	logic [AW-1:0] bidx_q;
	logic [UW-1:0] bu_q, bv_q;
	logic [gas_pkg::COST_W-1:0] bcost_q, ccost_q;
	logic [2:0] bdir_q, d_q;
	logic [AW-1:0] cur_q, nidx_q, sidx_q, gidx_q;
	logic [UW-1:0] cu_q, cv_q, gu_q, gv_q;
	logic [LW-1:0] n_q, i_q;
	logic found_q;
	logic [LW-1:0] len_q;

	logic c_we;
	logic [AW-1:0] c_waddr, c_raddr;
	gas_pkg::cell_t c_wdata, c_rd;
	logic [gas_pkg::CELL_W-1:0] c_rdata;

	logic signed [SW-1:0] nu_c, nv_c, pu_c, pv_c;
	logic n_on, p_on;
	logic [AW-1:0] nidx_c, pidx_c;
	logic [UW-1:0] hx_c, hy_c;
	logic [gas_pkg::F_W-1:0] f_c;
	logic [gas_pkg::COST_W-1:0] tent_c;

	gas_ram #(.WIDTH(gas_pkg::CELL_W), .DEPTH(NCELLS)) u_cell_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	function automatic logic [AW-1:0] idx_of(input logic [UW-1:0] u, input logic [UW-1:0] v);
		idx_of = AW'(u * SIDE + v);
	endfunction

	always_comb begin
		c_rd   = gas_pkg::cell_t'(c_rdata);
		nu_c   = $signed(SW'(cu_q)) + SW'(gas_pkg::DIR_DX[d_q]);
		nv_c   = $signed(SW'(cv_q)) + SW'(gas_pkg::DIR_DY[d_q]);
		n_on   = (nu_c >= 0) && (nu_c < SIDE_S) && (nv_c >= 0) && (nv_c < SIDE_S);
		nidx_c = idx_of(nu_c[UW-1:0], nv_c[UW-1:0]);
		pu_c   = $signed(SW'(cu_q)) - SW'(gas_pkg::DIR_DX[c_rd.dir]);
		pv_c   = $signed(SW'(cv_q)) - SW'(gas_pkg::DIR_DY[c_rd.dir]);
		p_on   = (pu_c >= 0) && (pu_c < SIDE_S) && (pv_c >= 0) && (pv_c < SIDE_S);
		pidx_c = idx_of(pu_c[UW-1:0], pv_c[UW-1:0]);
		hx_c   = (sel_u_s1 > gu_q) ? sel_u_s1 - gu_q : gu_q - sel_u_s1;
		hy_c   = (sel_w_s1 > gv_q) ? sel_w_s1 - gv_q : gv_q - sel_w_s1;
		f_c    = gas_pkg::F_W'(c_rd.cost) + gas_pkg::F_W'(hx_c) + gas_pkg::F_W'(hy_c);
		tent_c = (ccost_q >= gas_pkg::COST_MAX) ? gas_pkg::COST_MAX : ccost_q + 1'b1;
	end

	always_comb begin
		c_we    = 1'b0;
		c_waddr = sweep_q[AW-1:0];
		c_wdata = '{open: 1'b0, cost: gas_pkg::COST_INF, dir: 3'd0};
		c_raddr = cur_q;
		case (st_q)
			S_CLR: begin
				c_we = 1'b1;
			end
			S_INIT: begin
				c_we    = 1'b1;
				c_waddr = sidx_q;
				c_wdata = '{open: 1'b1, cost: '0, dir: 3'd0};
			end
			S_SEL: begin
				c_raddr = sweep_q[AW-1:0];
			end
			S_PICK: begin
				c_we    = have_q && (bidx_q != gidx_q);
				c_waddr = bidx_q;
				c_wdata = '{open: 1'b0, cost: bcost_q, dir: bdir_q};
			end
			S_NRD: begin
				c_raddr = nidx_c;
			end
			S_NWR: begin
				c_we    = !obs_rdata && (tent_c < c_rd.cost);
				c_waddr = nidx_q;
				c_wdata = '{open: 1'b1, cost: tent_c, dir: d_q};
			end
			default: begin
			end
		endcase
	end

	assign obs_raddr  = nidx_c;
	assign path_we    = (st_q == S_ST_RD);
	assign path_waddr = AW'(i_q - 1'b1);
	assign path_wdata = {cu_q, cv_q};
	assign stat       = '{done: (st_q == S_DONE), found: found_q};
	assign len        = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			sel_v_s1    <= 1'b0;
			sel_last_s1 <= 1'b0;
			have_q      <= 1'b0;
			found_q     <= 1'b0;
			len_q       <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (start) begin
						sidx_q <= idx_of(su, sv);
						gidx_q <= idx_of(gu, gv);
						gu_q   <= gu;
						gv_q   <= gv;
						cu_q   <= su;
						cv_q   <= sv;
						if (ok) begin
							sweep_q <= '0;
							st_q    <= S_CLR;
						end else begin
							found_q <= 1'b0;
							len_q   <= '0;
							st_q    <= S_DONE;
						end
					end
				end
				S_CLR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == LW'(NCELLS - 1)) begin
						st_q <= S_INIT;
					end
				end
				S_INIT: begin
					sweep_q  <= '0;
					swu_q    <= '0;
					swv_q    <= '0;
					have_q   <= 1'b0;
					sel_v_s1 <= 1'b0;
					st_q     <= S_SEL;
				end
				S_SEL: begin
					if (sweep_q < LW'(NCELLS)) begin
						sel_v_s1    <= 1'b1;
						sel_last_s1 <= (sweep_q == LW'(NCELLS - 1));
						sel_a_s1    <= sweep_q[AW-1:0];
						sel_u_s1    <= swu_q;
						sel_w_s1    <= swv_q;
						sweep_q     <= sweep_q + 1'b1;
						if (swv_q == UW'(SIDE - 1)) begin
							swv_q <= '0;
							swu_q <= swu_q + 1'b1;
						end else begin
							swv_q <= swv_q + 1'b1;
						end
					end else begin
						sel_v_s1 <= 1'b0;
					end
					if (sel_v_s1 && c_rd.open && (!have_q || f_c < bf_q)) begin
						have_q  <= 1'b1;
						bf_q    <= f_c;
						bidx_q  <= sel_a_s1;
						bu_q    <= sel_u_s1;
						bv_q    <= sel_w_s1;
						bcost_q <= c_rd.cost;
						bdir_q  <= c_rd.dir;
					end
					if (sel_v_s1 && sel_last_s1) begin
						st_q <= S_PICK;
					end
				end
				S_PICK: begin
					cur_q   <= bidx_q;
					cu_q    <= bu_q;
					cv_q    <= bv_q;
					ccost_q <= bcost_q;
					d_q     <= 3'd0;
					if (!have_q) begin
						found_q <= 1'b0;
						len_q   <= '0;
						st_q    <= S_DONE;
					end else if (bidx_q == gidx_q) begin
						n_q  <= LW'(1);
						st_q <= S_CNT_RD;
					end else begin
						st_q <= S_NRD;
					end
				end
				S_NRD: begin
					nidx_q <= nidx_c;
					if (n_on) begin
						st_q <= S_NWR;
					end else if (d_q == 3'd7) begin
						sweep_q  <= '0;
						swu_q    <= '0;
						swv_q    <= '0;
						have_q   <= 1'b0;
						sel_v_s1 <= 1'b0;
						st_q     <= S_SEL;
					end else begin
						d_q <= d_q + 1'b1;
					end
				end
				S_NWR: begin
					if (d_q == 3'd7) begin
						sweep_q  <= '0;
						swu_q    <= '0;
						swv_q    <= '0;
						have_q   <= 1'b0;
						sel_v_s1 <= 1'b0;
						st_q     <= S_SEL;
					end else begin
						d_q  <= d_q + 1'b1;
						st_q <= S_NRD;
					end
				end
				S_CNT_RD: begin
					if ((cur_q == sidx_q) || (n_q == LW'(NCELLS))) begin
						st_q <= S_ST_INI;
					end else begin
						st_q <= S_CNT_EV;
					end
				end
				S_CNT_EV: begin
					if (p_on) begin
						cur_q <= pidx_c;
						cu_q  <= pu_c[UW-1:0];
						cv_q  <= pv_c[UW-1:0];
						n_q   <= n_q + 1'b1;
						st_q  <= S_CNT_RD;
					end else begin
						st_q <= S_ST_INI;
					end
				end
				S_ST_INI: begin
					cur_q <= gidx_q;
					cu_q  <= gu_q;
					cv_q  <= gv_q;
					i_q   <= n_q;
					st_q  <= S_ST_RD;
				end
				S_ST_RD: begin
					if (i_q == LW'(1)) begin
						found_q <= 1'b1;
						len_q   <= n_q;
						st_q    <= S_DONE;
					end else begin
						st_q <= S_ST_EV;
					end
				end
				S_ST_EV: begin
					if (p_on) begin
						cur_q <= pidx_c;
						cu_q  <= pu_c[UW-1:0];
						cv_q  <= pv_c[UW-1:0];
					end
					i_q  <= i_q - 1'b1;
					st_q <= S_ST_RD;
				end
				S_DONE: begin
					st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
